// ===== hdl/cscan_pkg.sv =====
// ----------------------------------------------------------------------------
// C-SCAN disk scheduler package
// Sizes, codes and the result word shared by the scheduler and its testbench.
// ----------------------------------------------------------------------------
package cscan_pkg;

  localparam int NUM_REQUESTERS = 16;
  localparam int TRACK_BITS     = 16;

  localparam int ID_BITS  = (NUM_REQUESTERS > 2) ? $clog2(NUM_REQUESTERS) : 1;
  localparam int CNT_BITS = $clog2(NUM_REQUESTERS + 1);

  // Width of the output fields, fixed by the port list.
  localparam int OUT_ID_BITS    = 4;
  localparam int OUT_TRACK_BITS = 16;

  // One entry of the request store: sweep bit above the track.
  localparam int ENTRY_BITS = TRACK_BITS + 1;

  typedef enum logic {
    REQ_ACCESS  = 1'b0,
    REQ_RELEASE = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_DUPLICATE    = 2'd1,
    STATUS_IDLE_RELEASE = 2'd2
  } status_t;

  typedef struct packed {
    logic                      grant;
    logic [OUT_ID_BITS-1:0]    id;
    logic [OUT_TRACK_BITS-1:0] track;
    status_t                   status;
  } result_t;

endpackage

// ===== hdl/cscan_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module cscan_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/cscan_disk_request_scheduler.sv =====
// ----------------------------------------------------------------------------
// C-SCAN disk request scheduler
// Grants a disk to one requester at a time in one-way elevator order.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall) carries one word per request
//   or release. The response channel (rsp_valid, rsp_stall) returns exactly
//   one word for each, in order. A word moves when valid is high and stall
//   is low.
//   A request, and a release while the disk is idle, put the response word
//   into the holding register, from which it moves up to the output
//   register; the next word is accepted once it has left the holding one.
//   A release while the disk is busy scans every requester entry of the
//   track store, one read per cycle from its single read port. Its response
//   then passes a done state and the holding register on its way to the
//   output, and no further word is accepted before the scan and the done
//   state are over and the response has left the holding register.
//   Pending flags live in flip-flops; tracks and sweep bits sit in the RAM
//   and are only used for pending entries, so the RAM needs no clearing.
//   Reset leaves the disk idle with nothing pending, sweep 0, head track 0.
//   A response waits in the output register while the receiver stalls; one
//   more word can be accepted and its response held behind it, after which
//   req_stall stays high until the output drains.
// ----------------------------------------------------------------------------
module cscan_disk_request_scheduler import cscan_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        req_type,
  input  logic [3:0]  requester_id,
  input  logic [15:0] track,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        grant_valid,
  output logic [3:0]  granted_id,
  output logic [15:0] granted_track,
  output logic [1:0]  status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                  state;
  logic [NUM_REQUESTERS-1:0] pending;
  logic                    disk_busy;
  logic                    current_sweep;
  logic [TRACK_BITS-1:0]   head_track;

  logic [CNT_BITS-1:0]     rd_cnt;
  logic                    cmp_valid;
  logic [ID_BITS-1:0]      cmp_idx;
  logic [1:0]              found;
  logic [ID_BITS-1:0]      best_idx [2];
  logic [TRACK_BITS-1:0]   best_trk [2];

  result_t                 hold;
  logic                    hold_valid;
  result_t                 out_r;

  logic                    req_fire;
  logic [TRACK_BITS-1:0]   req_trk;
  logic [ID_BITS-1:0]      req_idx;
  logic                    req_in_range;
  logic                    req_new;
  logic                    req_sweep;
  result_t                 imm_res;

  logic                    ram_we;
  logic                    ram_re;
  logic [ID_BITS-1:0]      ram_raddr;
  logic [ENTRY_BITS-1:0]   ram_wdata;
  logic [ENTRY_BITS-1:0]   ram_rdata;

  logic [TRACK_BITS-1:0]   scan_trk;
  logic                    scan_sweep;
  logic                    scan_take;
  logic                    pick_sweep;
  logic                    pick_found;

  cscan_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (NUM_REQUESTERS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_stall = (state != ST_IDLE) || hold_valid;
  assign req_fire  = req_valid && !req_stall;

  assign req_trk      = TRACK_BITS'(track);
  assign req_idx      = ID_BITS'(requester_id);
  assign req_in_range = 32'(requester_id) < 32'(NUM_REQUESTERS);
  assign req_new      = req_in_range && !pending[req_idx];
  assign req_sweep    = (req_trk >= head_track) ? current_sweep : ~current_sweep;

  assign ram_we    = req_fire && (req_type == REQ_ACCESS) && req_new && disk_busy;
  assign ram_wdata = {req_sweep, req_trk};
  assign ram_re    = (state == ST_SCAN) && (rd_cnt < CNT_BITS'(NUM_REQUESTERS));
  assign ram_raddr = rd_cnt[ID_BITS-1:0];

  // The first entry seen with the lowest track wins, so ties go to the
  // lowest requester id.
  assign scan_trk   = ram_rdata[TRACK_BITS-1:0];
  assign scan_sweep = ram_rdata[TRACK_BITS];
  assign scan_take  = cmp_valid && pending[cmp_idx] &&
                      (!found[scan_sweep] || (scan_trk < best_trk[scan_sweep]));

  assign pick_sweep = found[current_sweep] ? current_sweep : ~current_sweep;
  assign pick_found = found[pick_sweep];

  always_comb begin
    imm_res = '{grant: 1'b0, id: '0, track: '0, status: STATUS_OK};
    if (req_type == REQ_RELEASE) begin
      imm_res.status = STATUS_IDLE_RELEASE;
    end else if (req_in_range && pending[req_idx]) begin
      imm_res.status = STATUS_DUPLICATE;
    end else if (req_in_range && !disk_busy) begin
      imm_res.grant = 1'b1;
      imm_res.id    = OUT_ID_BITS'(req_idx);
      imm_res.track = OUT_TRACK_BITS'(req_trk);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pending       <= '0;
      disk_busy     <= 1'b0;
      current_sweep <= 1'b0;
      head_track    <= '0;
      rd_cnt        <= '0;
      cmp_valid     <= 1'b0;
      found         <= '0;
      hold_valid    <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      // Output register drains first; the holding word moves up behind it.
      if (hold_valid && (!rsp_valid || !rsp_stall)) begin
        out_r      <= hold;
        rsp_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            if ((req_type == REQ_RELEASE) && disk_busy) begin
              state     <= ST_SCAN;
              rd_cnt    <= '0;
              cmp_valid <= 1'b0;
              found     <= '0;
            end else begin
              hold       <= imm_res;
              hold_valid <= 1'b1;
              if ((req_type == REQ_ACCESS) && req_new) begin
                if (!disk_busy) begin
                  disk_busy  <= 1'b1;
                  head_track <= req_trk;
                end else begin
                  pending[req_idx] <= 1'b1;
                end
              end
            end
          end
        end

        ST_SCAN: begin
          if (ram_re) begin
            rd_cnt <= rd_cnt + CNT_BITS'(1);
          end
          cmp_valid <= ram_re;
          cmp_idx   <= ram_raddr;
          if (scan_take) begin
            found[scan_sweep]    <= 1'b1;
            best_idx[scan_sweep] <= cmp_idx;
            best_trk[scan_sweep] <= scan_trk;
          end
          if (cmp_valid && (cmp_idx == ID_BITS'(NUM_REQUESTERS - 1))) begin
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          hold_valid <= 1'b1;
          state      <= ST_IDLE;
          if (pick_found) begin
            pending[best_idx[pick_sweep]] <= 1'b0;
            head_track    <= best_trk[pick_sweep];
            current_sweep <= pick_sweep;
            hold <= '{grant:  1'b1,
                      id:     OUT_ID_BITS'(best_idx[pick_sweep]),
                      track:  OUT_TRACK_BITS'(best_trk[pick_sweep]),
                      status: STATUS_OK};
          end else begin
            // Both sweeps are empty: the disk goes idle.
            current_sweep <= 1'b0;
            disk_busy     <= 1'b0;
            hold <= '{grant: 1'b0, id: '0, track: '0, status: STATUS_OK};
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign grant_valid   = out_r.grant;
  assign granted_id    = out_r.id;
  assign granted_track = out_r.track;
  assign status        = out_r.status;

endmodule

// ===== test/tb_cscan_disk_request_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the C-SCAN disk request scheduler
// Sends request and release words through a stalling handshake, predicts
// every response with a one-way elevator model kept in the testbench, and
// compares each returned word field by field in order.
// ----------------------------------------------------------------------------
module tb_cscan_disk_request_scheduler import cscan_pkg::*;;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_WORDS = 1880;
  localparam int CALM_TAIL    = 150;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    req_kind_t   kind;
    logic [3:0]  id;
    logic [15:0] trk;
  } disk_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        req_type = 1'b0;
  logic [3:0]  requester_id = '0;
  logic [15:0] track = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic        grant_valid;
  logic [3:0]  granted_id;
  logic [15:0] granted_track;
  logic [1:0]  status;

  disk_word_t word_queue[$];
  result_t    expected_grants[$];

  // Scheduler state as seen by the predictor.
  logic              waiting       [NUM_REQUESTERS];
  logic              waiting_sweep [NUM_REQUESTERS];
  logic [15:0]       waiting_track [NUM_REQUESTERS];
  logic              sweep_now = 1'b0;
  logic              disk_held = 1'b0;
  logic [15:0]       head_pos  = '0;

  int   cycle_count    = 0;
  int   error_count    = 0;
  int   words_accepted = 0;
  int   words_sent     = 0;
  int   send_gap       = 0;
  int   recv_gap       = 0;
  logic word_taken     = 1'b0;
  logic hold_rsp       = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cscan_disk_request_scheduler u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .requester_id (requester_id),
    .track        (track),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .grant_valid  (grant_valid),
    .granted_id   (granted_id),
    .granted_track(granted_track),
    .status       (status)
  );

  initial begin
    for (int i = 0; i < NUM_REQUESTERS; i++) begin
      waiting[i]       = 1'b0;
      waiting_sweep[i] = 1'b0;
      waiting_track[i] = '0;
    end
  end

  // Lowest pending track in the given sweep; ties resolve to the lower id.
  function automatic int lowest_in_sweep(logic sweep);
    int best = -1;
    for (int i = 0; i < NUM_REQUESTERS; i++) begin
      if (waiting[i] && waiting_sweep[i] == sweep) begin
        if (best < 0 || waiting_track[i] < waiting_track[best]) best = i;
      end
    end
    return best;
  endfunction

  function automatic result_t schedule_word(disk_word_t w);
    result_t r;
    int      pick;
    r = '{grant: 1'b0, id: '0, track: '0, status: STATUS_OK};
    if (w.kind == REQ_ACCESS) begin
      if (waiting[w.id]) begin
        r.status = STATUS_DUPLICATE;
      end else if (!disk_held) begin
        disk_held = 1'b1;
        head_pos  = w.trk;
        r.grant   = 1'b1;
        r.id      = w.id;
        r.track   = w.trk;
      end else begin
        waiting[w.id]       = 1'b1;
        waiting_track[w.id] = w.trk;
        waiting_sweep[w.id] = (w.trk >= head_pos) ? sweep_now : ~sweep_now;
      end
    end else if (!disk_held) begin
      r.status = STATUS_IDLE_RELEASE;
    end else begin
      pick = lowest_in_sweep(sweep_now);
      if (pick < 0) begin
        sweep_now = ~sweep_now;
        pick = lowest_in_sweep(sweep_now);
      end
      if (pick < 0) begin
        sweep_now = 1'b0;
        disk_held = 1'b0;
      end else begin
        waiting[pick] = 1'b0;
        head_pos      = waiting_track[pick];
        r.grant       = 1'b1;
        r.id          = 4'(pick);
        r.track       = waiting_track[pick];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int exp_val, int act_val);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
    error_count++;
  endtask

  // Sampling side: acceptance on both channels, prediction and checking.
  always @(posedge clk) begin
    result_t want;
    disk_word_t w;
    cycle_count++;
    word_taken = 1'b0;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (!rst) begin
      if (req_valid && !req_stall) begin
        word_taken = 1'b1;
        w.kind = req_kind_t'(req_type);
        w.id   = requester_id;
        w.trk  = track;
        expected_grants.push_back(schedule_word(w));
        words_accepted++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_grants.size() == 0) begin
          $display({"%0t: response word with nothing expected ",
                    "(grant %0b id %0h track %0h status %0d)"},
                   $time, grant_valid, granted_id, granted_track, status);
          error_count++;
        end else begin
          want = expected_grants.pop_front();
          if (grant_valid !== want.grant)
            report_mismatch("grant_valid", want.grant, grant_valid);
          if (granted_id !== want.id)
            report_mismatch("granted_id", want.id, granted_id);
          if (granted_track !== want.track)
            report_mismatch("granted_track", want.track, granted_track);
          if (status !== want.status)
            report_mismatch("status", want.status, status);
        end
      end
    end
  end

  // Request driver: a new word is offered only once the previous one was taken.
  always @(negedge clk) begin
    disk_word_t w;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || word_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (word_queue.size() > 0) begin
        w = word_queue.pop_front();
        req_type     <= w.kind;
        requester_id <= w.id;
        track        <= w.trk;
        req_valid    <= 1'b1;
        words_sent++;
        // Idle bursts come in stretches, with calm stretches between them.
        if (word_queue.size() > CALM_TAIL && (words_sent % 300) < 200 &&
            $urandom_range(0, 99) < 15)
          send_gap = $urandom_range(1, 15);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response side stall.
  always @(negedge clk) begin
    if (recv_gap > 0) begin
      recv_gap--;
    end else if (word_queue.size() > CALM_TAIL && (words_sent % 400) >= 100 &&
                 $urandom_range(0, 99) < 12) begin
      recv_gap = $urandom_range(1, 15);
    end
    rsp_stall <= hold_rsp || (recv_gap > 0);
  end

  // One long hold-off on the response side while words keep arriving.
  initial begin
    do @(posedge clk); while (words_accepted < 400);
    hold_rsp = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp = 1'b0;
  end

  task automatic add_word(req_kind_t kind, logic [3:0] id, logic [15:0] trk);
    disk_word_t w;
    w.kind = kind;
    w.id   = id;
    w.trk  = trk;
    word_queue.push_back(w);
  endtask

  initial begin
    logic [15:0] tie_tracks [4];
    int          release_pct;
    int          pick;
    logic [15:0] trk;
    tie_tracks = '{16'h0100, 16'h4000, 16'h8000, 16'hC000};

    // Directed opening: idle release, sweep placement, ties, duplicate,
    // holder asking again, sweep swap and the return to idle.
    add_word(REQ_RELEASE, 4'h0, 16'h0000);
    add_word(REQ_ACCESS,  4'h0, 16'h8000);
    add_word(REQ_ACCESS,  4'h5, 16'hFFFF);
    add_word(REQ_ACCESS,  4'h3, 16'h1000);
    add_word(REQ_ACCESS,  4'h7, 16'hFFFF);
    add_word(REQ_ACCESS,  4'h5, 16'h0000);
    add_word(REQ_ACCESS,  4'h0, 16'h9000);
    add_word(REQ_ACCESS,  4'hF, 16'h8000);
    add_word(REQ_ACCESS,  4'hC, 16'h0000);
    add_word(REQ_ACCESS,  4'hA, 16'h5555);
    add_word(REQ_ACCESS,  4'h9, 16'hAAAA);
    repeat (9) add_word(REQ_RELEASE, 4'hF, 16'hFFFF);
    add_word(REQ_RELEASE, 4'h0, 16'h0000);
    add_word(REQ_ACCESS,  4'hF, 16'h0000);
    add_word(REQ_ACCESS,  4'h1, 16'h0000);
    add_word(REQ_RELEASE, 4'h0, 16'h0000);
    add_word(REQ_RELEASE, 4'h0, 16'h0000);

    // Random part in segments whose release rate varies, so the pending set
    // grows, drains and sometimes empties completely.
    release_pct = 45;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) begin
        pick = $urandom_range(0, 2);
        release_pct = (pick == 0) ? 25 : (pick == 1) ? 45 : 70;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0)      trk = 16'h0000;
      else if (pick == 1) trk = 16'hFFFF;
      else if (pick < 4)  trk = tie_tracks[$urandom_range(0, 3)];
      else                trk = 16'($urandom);
      if ($urandom_range(0, 99) < release_pct)
        add_word(REQ_RELEASE, 4'($urandom), trk);
      else
        add_word(REQ_ACCESS, 4'($urandom_range(0, 15)), trk);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (word_queue.size() != 0 || req_valid || expected_grants.size() != 0);
    repeat (40) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
